@@ sv/bfdh_pkg.sv @@
// shared types, constants and codes of the double-hash bloom filter
package bfdh_pkg;

  localparam int unsigned HASH_W          = 32;
  localparam int unsigned ROT_RIGHT       = 17;
  localparam int unsigned MAX_FILTER_BITS = 8192;
  localparam int unsigned MIN_FILTER_BITS = 64;

  // store rows hold this many filter bits
  localparam int unsigned ROW_BITS  = 8;
  localparam int unsigned ROW_SEL_W = $clog2(ROW_BITS);

  // hash reduction retires this many dividend bits per cycle
  localparam int unsigned RED_BITS  = 4;
  localparam int unsigned RED_STEPS = HASH_W / RED_BITS;
  localparam int unsigned RED_CNT_W = $clog2(RED_STEPS + 1);

  localparam int unsigned FB_W       = 14;
  localparam int unsigned HC_W       = 5;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [FB_W-1:0] FB_RESET = FB_W'(8192);
  localparam logic [HC_W-1:0] HC_RESET = HC_W'(6);

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = CFG_IDX_W'(1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [HASH_W-1:0] key_hash;
  } in_item_t;

  typedef struct packed {
    logic was_query;
    logic maybe_present;
  } out_item_t;

  // probe request control toward the store
  typedef struct packed {
    logic vld;
    logic set;
  } probe_ctl_t;

  // store status and probe response
  typedef struct packed {
    logic clearing;
    logic rsp_vld;
    logic rsp_hit;
  } store_sts_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_PROBE,
    ST_DRAIN
  } state_t;

endpackage

@@ sv/bloom_filter_double_hash_core.sv @@
// top level of the double-hash bloom filter: config, sequencing and probe walk
//
//   port group   direction  handshake            payload
//   in_          in         start & !busy        in_item  (command, key_hash)
//   out_         out        out_valid, 1 cycle   out_item (was_query, maybe_present)
//   cfg_         in         cfg_valid & ready    cfg_index, cfg_data
//
// an item runs from one accepted start through hash reduction (8 steps of 4 bits
// of both hashes, then the handover), hash_count probes on the store read port
// and a drain of the store, then back to idle, where the next start is taken.
// after reset the store is zeroed one row per cycle, MAX_FILTER_BITS/8 rows
// (1024 by default), with busy high; cfg writes are taken throughout.
// the result strobe cannot be stalled; the next start may coincide with it.
module bloom_filter_double_hash_core #(
  parameter int unsigned MAX_FILTER_BITS = bfdh_pkg::MAX_FILTER_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  bfdh_pkg::in_item_t               in_item,
  output logic                             out_valid,
  output bfdh_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfdh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned PW = $clog2(MAX_FILTER_BITS);
  localparam int unsigned MW = PW + 1;
  localparam int unsigned CW = (MW > bfdh_pkg::FB_W) ? MW : bfdh_pkg::FB_W;

  bfdh_pkg::state_t state_r, state_nxt;

  logic [bfdh_pkg::FB_W-1:0] filter_bits_r;
  logic [bfdh_pkg::HC_W-1:0] hash_count_r;

  logic                      cmd_r;
  logic [MW-1:0]             m_r;
  logic [PW-1:0]             pos_r, step_r, pos_nxt;
  logic [bfdh_pkg::HC_W-1:0] left_r;
  logic                      present_r, present_fin;
  logic                      out_valid_r;
  bfdh_pkg::out_item_t       out_item_r;

  logic [CW-1:0]             fb_ext;
  logic [MW-1:0]             mod_eff;
  logic [bfdh_pkg::HASH_W-1:0] h2;
  logic [PW:0]               pos_sum;

  logic                      accept;
  logic                      mod_load, mod_done;
  logic [MW-1:0]             rem_a, rem_b;

  bfdh_pkg::probe_ctl_t      ctl;
  bfdh_pkg::store_sts_t      sts;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_bits_r <= bfdh_pkg::FB_RESET;
      hash_count_r  <= bfdh_pkg::HC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bfdh_pkg::CFG_FILTER_BITS: filter_bits_r <= cfg_data[bfdh_pkg::FB_W-1:0];
        bfdh_pkg::CFG_HASH_COUNT:  hash_count_r  <= cfg_data[bfdh_pkg::HC_W-1:0];
        default: ;
      endcase
    end
  end

  // modulus clamped into the store size
  always_comb begin
    fb_ext = CW'(filter_bits_r);
    if (fb_ext < CW'(bfdh_pkg::MIN_FILTER_BITS)) begin
      fb_ext = CW'(bfdh_pkg::MIN_FILTER_BITS);
    end else if (fb_ext > CW'(MAX_FILTER_BITS)) begin
      fb_ext = CW'(MAX_FILTER_BITS);
    end
    mod_eff = fb_ext[MW-1:0];
  end

  assign h2 = {in_item.key_hash[bfdh_pkg::ROT_RIGHT-1:0],
               in_item.key_hash[bfdh_pkg::HASH_W-1:bfdh_pkg::ROT_RIGHT]};

  bfdh_mod_unit #(
    .MW (MW)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (mod_load),
    .a_in    (in_item.key_hash),
    .b_in    (h2),
    .modulus (mod_eff),
    .done    (mod_done),
    .rem_a   (rem_a),
    .rem_b   (rem_b)
  );

  bfdh_bit_store #(
    .MAX_FILTER_BITS (MAX_FILTER_BITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .addr  (pos_r),
    .sts   (sts)
  );

  // incremental modular step to the next probe
  always_comb begin
    pos_sum = {1'b0, pos_r} + {1'b0, step_r};
    if (pos_sum >= m_r) begin
      pos_sum = pos_sum - m_r;
    end
    pos_nxt = pos_sum[PW-1:0];
  end

  assign present_fin = present_r && (!sts.rsp_vld || sts.rsp_hit);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfdh_pkg::ST_CLEAR: begin
        if (!sts.clearing) state_nxt = bfdh_pkg::ST_IDLE;
      end
      bfdh_pkg::ST_IDLE: begin
        if (start) state_nxt = bfdh_pkg::ST_REDUCE;
      end
      bfdh_pkg::ST_REDUCE: begin
        if (mod_done) begin
          state_nxt = (left_r == '0) ? bfdh_pkg::ST_DRAIN : bfdh_pkg::ST_PROBE;
        end
      end
      bfdh_pkg::ST_PROBE: begin
        if (left_r == bfdh_pkg::HC_W'(1)) state_nxt = bfdh_pkg::ST_DRAIN;
      end
      bfdh_pkg::ST_DRAIN: state_nxt = bfdh_pkg::ST_IDLE;
      default:            state_nxt = bfdh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state_r != bfdh_pkg::ST_IDLE);
    mod_load = (state_r == bfdh_pkg::ST_IDLE) && start;
    ctl.vld  = (state_r == bfdh_pkg::ST_PROBE);
    ctl.set  = (cmd_r == bfdh_pkg::CMD_INSERT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfdh_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == bfdh_pkg::ST_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_item.command;
      m_r       <= mod_eff;
      left_r    <= hash_count_r;
      present_r <= 1'b1;
    end else begin
      if (state_r == bfdh_pkg::ST_REDUCE && mod_done) begin
        pos_r  <= rem_a[PW-1:0];
        step_r <= rem_b[PW-1:0];
      end
      if (state_r == bfdh_pkg::ST_PROBE) begin
        pos_r  <= pos_nxt;
        left_r <= left_r - 1'b1;
      end
      if (sts.rsp_vld) begin
        present_r <= present_r && sts.rsp_hit;
      end
    end
    if (state_r == bfdh_pkg::ST_DRAIN) begin
      out_item_r.was_query     <= (cmd_r == bfdh_pkg::CMD_QUERY);
      out_item_r.maybe_present <= (cmd_r == bfdh_pkg::CMD_INSERT) || present_fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == bfdh_pkg::ST_DRAIN))
    else $error("result strobe without a finished item");

  a_no_probe_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld |-> !sts.clearing)
    else $error("probe issued while store is clearing");

  a_insert_ack_present: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.was_query) |-> out_item.maybe_present)
    else $error("insert acknowledged without maybe_present");

  a_accept_reduces: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == bfdh_pkg::ST_REDUCE))
    else $error("accepted item did not enter hash reduction");

  a_no_rsp_out_of_walk: assert property (@(posedge clk) disable iff (!rst_n)
    sts.rsp_vld |-> (state_r == bfdh_pkg::ST_PROBE || state_r == bfdh_pkg::ST_DRAIN))
    else $error("store response outside the probe walk");

endmodule

@@ sv/bfdh_mod_unit.sv @@
// multi-cycle reduction of the two key hashes modulo the filter length
module bfdh_mod_unit #(
  parameter int unsigned MW = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [bfdh_pkg::HASH_W-1:0] a_in,
  input  logic [bfdh_pkg::HASH_W-1:0] b_in,
  input  logic [MW-1:0]              modulus,
  output logic                       done,
  output logic [MW-1:0]              rem_a,
  output logic [MW-1:0]              rem_b
);

  logic [bfdh_pkg::HASH_W-1:0]    a_r, b_r;
  logic [MW-1:0]                  m_r, ra_r, rb_r;
  logic [MW-1:0]                  ra_nxt, rb_nxt;
  logic [bfdh_pkg::RED_CNT_W-1:0] cnt_r;
  logic                           busy_r, done_r;

  // one restoring step: shift in a dividend bit, subtract once if needed
  function automatic logic [MW-1:0] red_step(input logic [MW-1:0] r, input logic b,
                                             input logic [MW-1:0] m);
    logic [MW:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[MW-1:0];
  endfunction

  always_comb begin
    ra_nxt = ra_r;
    rb_nxt = rb_r;
    for (int k = 0; k < int'(bfdh_pkg::RED_BITS); k++) begin
      ra_nxt = red_step(ra_nxt, a_r[bfdh_pkg::HASH_W-1-k], m_r);
      rb_nxt = red_step(rb_nxt, b_r[bfdh_pkg::HASH_W-1-k], m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= bfdh_pkg::RED_CNT_W'(bfdh_pkg::RED_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == bfdh_pkg::RED_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r  <= a_in;
      b_r  <= b_in;
      m_r  <= modulus;
      ra_r <= '0;
      rb_r <= '0;
    end else if (busy_r) begin
      a_r  <= a_r << bfdh_pkg::RED_BITS;
      b_r  <= b_r << bfdh_pkg::RED_BITS;
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
    end
  end

  assign done  = done_r;
  assign rem_a = ra_r;
  assign rem_b = rb_r;

endmodule

@@ sv/bfdh_bit_store.sv @@
// row-organized filter bit memory with read-modify-write, forwarding and clear pass
module bfdh_bit_store #(
  parameter int unsigned MAX_FILTER_BITS = bfdh_pkg::MAX_FILTER_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bfdh_pkg::probe_ctl_t                ctl,
  input  logic [$clog2(MAX_FILTER_BITS)-1:0]  addr,
  output bfdh_pkg::store_sts_t                sts
);

  localparam int unsigned PW   = $clog2(MAX_FILTER_BITS);
  localparam int unsigned RW   = PW - bfdh_pkg::ROW_SEL_W;
  localparam int unsigned ROWS = (MAX_FILTER_BITS + bfdh_pkg::ROW_BITS - 1) /
                                 bfdh_pkg::ROW_BITS;

  logic [bfdh_pkg::ROW_BITS-1:0] mem [ROWS];

  logic [RW-1:0]                  req_row;
  logic [bfdh_pkg::ROW_SEL_W-1:0] req_sel;

  logic [bfdh_pkg::ROW_BITS-1:0]  rdata_r;
  logic                           rd_vld_r, rd_set_r;
  logic [RW-1:0]                  rd_row_r;
  logic [bfdh_pkg::ROW_SEL_W-1:0] rd_sel_r;

  logic                           wr_vld_r;
  logic [RW-1:0]                  wr_row_r;
  logic [bfdh_pkg::ROW_BITS-1:0]  wr_data_r;

  logic                           clearing_r;
  logic [RW-1:0]                  clr_row_r;

  logic [bfdh_pkg::ROW_BITS-1:0]  cur_row, new_row;
  logic                           rmw_we;
  logic                           mem_we;
  logic [RW-1:0]                  mem_wrow;
  logic [bfdh_pkg::ROW_BITS-1:0]  mem_wdata;

  assign req_row = addr[PW-1:bfdh_pkg::ROW_SEL_W];
  assign req_sel = addr[bfdh_pkg::ROW_SEL_W-1:0];

  // the read issued in the same cycle as a write to its row saw the old row
  always_comb begin
    cur_row = rdata_r;
    if (wr_vld_r && (wr_row_r == rd_row_r)) begin
      cur_row = rdata_r | wr_data_r;
    end
    new_row = cur_row;
    new_row[rd_sel_r] = 1'b1;
  end

  assign rmw_we    = rd_vld_r && rd_set_r;
  assign mem_we    = clearing_r || rmw_we;
  assign mem_wrow  = clearing_r ? clr_row_r : rd_row_r;
  assign mem_wdata = clearing_r ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wrow] <= mem_wdata;
    end
    if (ctl.vld) begin
      rdata_r <= mem[req_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      wr_vld_r   <= 1'b0;
      clearing_r <= 1'b1;
      clr_row_r  <= '0;
    end else begin
      rd_vld_r <= ctl.vld;
      wr_vld_r <= rmw_we;
      if (clearing_r) begin
        clr_row_r <= clr_row_r + 1'b1;
        if (clr_row_r == RW'(ROWS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_set_r  <= ctl.set;
    rd_row_r  <= req_row;
    rd_sel_r  <= req_sel;
    wr_row_r  <= rd_row_r;
    wr_data_r <= new_row;
  end

  assign sts.clearing = clearing_r;
  assign sts.rsp_vld  = rd_vld_r;
  assign sts.rsp_hit  = cur_row[rd_sel_r];

endmodule
